>>> hdl/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

   // reset values of the start registers and the running bases
   localparam logic [31:0] IO_START_RST   = 32'h0001_0000;
   localparam logic [31:0] MEM_ORIGIN_RST = 32'h0100_0000;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic CSR_IO_START   = 1'b0;
   localparam logic CSR_MEM_ORIGIN = 1'b1;

   // request opcodes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_ALIGN   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   // offset of the second 16 MB octant and span of one 128 MB segment
   localparam logic [26:0] OCTANT_OFF   = 27'h100_0000;
   localparam logic [27:0] SEGMENT_SPAN = 28'h800_0000;

   // bus boundary masks (4 KB for I/O, 1 MB for memory)
   localparam logic [32:0] IO_BUS_MASK  = 33'h0_0000_0FFF;
   localparam logic [32:0] MEM_BUS_MASK = 33'h0_000F_FFFF;

   typedef enum logic [2:0] {
      ST_IO      = 3'd0,
      ST_MEM     = 3'd1,
      ST_LARGE   = 3'd2,
      ST_SKIP64  = 3'd3,
      ST_SKIP1M  = 3'd4,
      ST_ABSENT  = 3'd5,
      ST_NOSPACE = 3'd6,
      ST_BASES   = 3'd7
   } status_type;

   // work class decided by the front end
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_ALIGN,
      KIND_RESTART,
      KIND_ABSENT,
      KIND_IO,
      KIND_MEM,
      KIND_SKIP64,
      KIND_SKIP1M
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] size;
      logic [31:0] size_mask;
      logic        sparse;    // memory region of at most 64 MB
      logic [26:0] move_off;  // segment offset used when the region is moved
   } pba_item_type;

   typedef struct packed {
      logic         valid;
      pba_item_type item;
   } pba_qport_type;

endpackage
`default_nettype wire

>>> hdl/pba_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pba_front import pba_pkg::*; (
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_op,
   input  wire logic [31:0]   req_bar_readback,
   input  wire logic          q_full,
   output pba_qport_type      q_wr
);

   logic [31:0] addr_bits;
   logic [31:0] low_bit;

   // take a word whenever the queue has room
   assign req_ready = !q_full;

   always_comb begin
      q_wr.valid = req_valid && !q_full;

      // isolate the address bits and pick the lowest set one as the size
      addr_bits = req_bar_readback[0] ? (req_bar_readback & 32'hFFFF_FFFC)
                                      : (req_bar_readback & 32'hFFFF_FFF0);
      low_bit   = addr_bits & (~addr_bits + 32'd1);

      q_wr.item.size      = low_bit;
      q_wr.item.size_mask = low_bit - 32'd1;
      q_wr.item.sparse    = (low_bit[31:27] == 5'd0);
      q_wr.item.move_off  = (low_bit[26:24] != 3'd0) ? low_bit[26:0] : OCTANT_OFF;

      // classify the word
      unique case (req_op)
         OP_ALLOC: begin
            if (low_bit == 32'd0) begin
               q_wr.item.kind = KIND_ABSENT;
            end else if (req_bar_readback[0]) begin
               q_wr.item.kind = KIND_IO;
            end else begin
               case (req_bar_readback[2:1])
                  2'd2:    q_wr.item.kind = KIND_SKIP64;
                  2'd1:    q_wr.item.kind = KIND_SKIP1M;
                  default: q_wr.item.kind = KIND_MEM;
               endcase
            end
         end
         OP_ALIGN:   q_wr.item.kind = KIND_ALIGN;
         OP_RESTART: q_wr.item.kind = KIND_RESTART;
         OP_UNUSED:  q_wr.item.kind = KIND_NOP;
         default:    q_wr.item.kind = KIND_NOP;
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/pba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pba_queue import pba_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pba_qport_type q_wr,
   output logic               q_full,
   output pba_qport_type      q_rd,
   input  wire logic          q_pop
);

   localparam int unsigned AddrW = $clog2(Depth);
   localparam int unsigned CntW  = $clog2(Depth + 1);

   pba_item_type entry_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign q_full     = (count_ff == CntW'(Depth));
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.item  = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_wr.valid) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(q_wr.valid) - CntW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (q_wr.valid) begin
         entry_ff[wr_ptr_ff] <= q_wr.item;
      end
   end

endmodule
`default_nettype wire

>>> hdl/pba_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pba_back import pba_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pba_qport_type q_rd,
   output logic               q_pop,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_index,
   input  wire logic [31:0]   csr_wdata,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_assigned_base,
   output logic [31:0]        rsp_region_size,
   output logic [31:0]        rsp_bar_write_value,
   output logic [31:0]        rsp_io_next,
   output logic [31:0]        rsp_mem_next
);

   pba_item_type item;

   logic [31:0] io_start_ff, mem_origin_ff;
   logic [31:0] next_io_ff, next_io_in;
   logic [31:0] next_mem_ff, next_mem_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_base_ff, rsp_base_in;
   logic [31:0] rsp_size_ff, rsp_size_in;
   logic [31:0] rsp_wv_ff, rsp_wv_in;

   logic [32:0] io_aligned, io_end;
   logic [32:0] mem_aligned, mem_place, mem_end;
   logic [26:0] mem_off;
   logic        oct_zero, seg_cross;
   logic [32:0] io_bus, mem_bus;

   assign item  = q_rd.item;
   assign q_pop = q_rd.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      // align the running bases to the region size
      io_aligned  = ({1'b0, next_io_ff} + {1'b0, item.size_mask}) & ~{1'b0, item.size_mask};
      io_end      = io_aligned + {1'b0, item.size};
      mem_aligned = ({1'b0, next_mem_ff} + {1'b0, item.size_mask})
                    & ~{1'b0, item.size_mask};

      // keep small regions out of the first octant and off the segment end
      oct_zero  = (mem_aligned[26:24] == 3'd0);
      mem_off   = (item.sparse && oct_zero) ? item.move_off : mem_aligned[26:0];
      seg_cross = item.sparse
                  && (({1'b0, mem_off} + {1'b0, item.size[26:0]}) == SEGMENT_SPAN);
      if (!item.sparse) begin
         mem_place = mem_aligned;
      end else if (seg_cross) begin
         mem_place = {mem_aligned[32:27] + 6'd1, item.move_off};
      end else begin
         mem_place = {mem_aligned[32:27], mem_off};
      end
      mem_end = mem_place + {1'b0, item.size};

      // bus boundary alignment
      io_bus  = ({1'b0, next_io_ff} + IO_BUS_MASK) & ~IO_BUS_MASK;
      mem_bus = ({1'b0, next_mem_ff} + MEM_BUS_MASK) & ~MEM_BUS_MASK;

      rsp_status_in = ST_BASES;
      rsp_base_in   = 32'd0;
      rsp_size_in   = 32'd0;
      rsp_wv_in     = 32'd0;
      next_io_in    = next_io_ff;
      next_mem_in   = next_mem_ff;

      unique case (item.kind)
         KIND_NOP: begin
            rsp_status_in = ST_BASES;
         end
         KIND_RESTART: begin
            next_io_in  = io_start_ff;
            next_mem_in = mem_origin_ff;
         end
         KIND_ALIGN: begin
            if (io_bus[32] || mem_bus[32]) begin
               rsp_status_in = ST_NOSPACE;
            end else begin
               next_io_in  = io_bus[31:0];
               next_mem_in = mem_bus[31:0];
            end
         end
         KIND_ABSENT: begin
            rsp_status_in = ST_ABSENT;
         end
         KIND_SKIP64: begin
            rsp_status_in = ST_SKIP64;
            rsp_size_in   = item.size;
         end
         KIND_SKIP1M: begin
            rsp_status_in = ST_SKIP1M;
            rsp_size_in   = item.size;
         end
         KIND_IO: begin
            if (io_end[32]) begin
               rsp_status_in = ST_NOSPACE;
            end else begin
               rsp_status_in = ST_IO;
               rsp_base_in   = io_aligned[31:0];
               rsp_size_in   = item.size;
               rsp_wv_in     = io_aligned[31:0] | 32'd1;
               next_io_in    = io_end[31:0];
            end
         end
         KIND_MEM: begin
            if (mem_end[32]) begin
               rsp_status_in = ST_NOSPACE;
            end else begin
               rsp_status_in = item.sparse ? ST_MEM : ST_LARGE;
               rsp_base_in   = mem_place[31:0];
               rsp_size_in   = item.size;
               rsp_wv_in     = mem_place[31:0];
               next_mem_in   = mem_end[31:0];
            end
         end
      endcase

      // hold the result until taken, refill on pop
      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         io_start_ff   <= IO_START_RST;
         mem_origin_ff <= MEM_ORIGIN_RST;
         next_io_ff    <= IO_START_RST;
         next_mem_ff   <= MEM_ORIGIN_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == CSR_IO_START) begin
            io_start_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == CSR_MEM_ORIGIN) begin
            mem_origin_ff <= csr_wdata;
         end
         if (q_pop) begin
            next_io_ff  <= next_io_in;
            next_mem_ff <= next_mem_in;
         end
      end
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_status_ff <= rsp_status_in;
         rsp_base_ff   <= rsp_base_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_wv_ff     <= rsp_wv_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_assigned_base   = rsp_base_ff;
   assign rsp_region_size     = rsp_size_ff;
   assign rsp_bar_write_value = rsp_wv_ff;
   assign rsp_io_next         = next_io_ff;
   assign rsp_mem_next        = next_mem_ff;

endmodule
`default_nettype wire

>>> hdl/pci_bar_address_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// PCI BAR allocator: each request word is one BAR readback to size and place, a bus
// boundary alignment of the I/O and memory bases, a restart of both bases from the
// two start registers, or a no-op; every request gives exactly one response word.
// The block takes one word per cycle while its queue has room; the back end pops a
// word from the queue, aligns and advances both running bases, and registers the
// response word. A queue of QueueDepth words in front of it keeps the request side
// flowing while the response side stalls, until it fills. Write the start registers
// only while no request is in flight.
module pci_bar_address_allocator import pba_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_bar_readback,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_assigned_base,
   output logic [31:0]      rsp_region_size,
   output logic [31:0]      rsp_bar_write_value,
   output logic [31:0]      rsp_io_next,
   output logic [31:0]      rsp_mem_next,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   pba_qport_type q_wr;
   pba_qport_type q_rd;
   logic          q_full;
   logic          q_pop;

   // classify requests
   pba_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_bar_readback (req_bar_readback),
      .q_full           (q_full),
      .q_wr             (q_wr)
   );

   // decouple front and back
   pba_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // place regions and advance bases
   pba_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_rd                (q_rd),
      .q_pop               (q_pop),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_assigned_base   (rsp_assigned_base),
      .rsp_region_size     (rsp_region_size),
      .rsp_bar_write_value (rsp_bar_write_value),
      .rsp_io_next         (rsp_io_next),
      .rsp_mem_next        (rsp_mem_next)
   );

endmodule
`default_nettype wire

>>> hdl/pba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pba_checker import pba_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_assigned_base,
   input wire logic [31:0] rsp_region_size,
   input wire logic [31:0] rsp_bar_write_value,
   input wire logic [31:0] rsp_io_next,
   input wire logic [31:0] rsp_mem_next
);

   logic         rsp_stall;
   logic [162:0] rsp_word;
   logic [31:0]  base_misalign;
   logic         io_placed;
   logic         mem_placed;
   logic         none_placed;
   logic         io_ok;
   logic         mem_ok;
   logic         fields_zero;

   // collect the response word and the placement conditions
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_word      = {rsp_status, rsp_assigned_base, rsp_region_size,
                           rsp_bar_write_value, rsp_io_next, rsp_mem_next};
   assign base_misalign = rsp_assigned_base & (rsp_region_size - 32'd1);
   assign io_placed     = rsp_valid && rsp_status == ST_IO;
   assign mem_placed    = rsp_valid && (rsp_status == ST_MEM || rsp_status == ST_LARGE);
   assign none_placed   = rsp_valid && (rsp_status == ST_ABSENT
                                        || rsp_status == ST_NOSPACE
                                        || rsp_status == ST_BASES);
   assign io_ok         = rsp_bar_write_value == (rsp_assigned_base | 32'd1)
                          && base_misalign == 32'd0;
   assign mem_ok        = rsp_bar_write_value == rsp_assigned_base
                          && base_misalign == 32'd0;
   assign fields_zero   = rsp_assigned_base == 32'd0 && rsp_region_size == 32'd0
                          && rsp_bar_write_value == 32'd0;

   // a stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // no response right out of reset
   `ASSERT_IMPLIES(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // I/O placement is size aligned and written back with bit 0 set
   `ASSERT_IMPLIES(a_io_place, clock, reset, io_placed, io_ok)

   // memory placement is size aligned and written back as is
   `ASSERT_IMPLIES(a_mem_place, clock, reset, mem_placed, mem_ok)

   // nothing placed means all placement fields are zero
   `ASSERT_IMPLIES(a_no_place, clock, reset, none_placed, fields_zero)

endmodule

bind pci_bar_address_allocator pba_checker u_checker (.*);
`default_nettype wire
